// ===== rtl/dws_pkg.sv =====
`timescale 1ns / 1ps

package dws_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_REAR   = 2'd2,
        OP_SEARCH     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN
    } state_t;

    typedef enum logic [1:0] {
        RK_STATUS,
        RK_POP,
        RK_HIT
    } rsp_kind_t;

    typedef struct packed {
        op_t                       operation;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] popped_value;
        logic [POS_W-1:0]          found_position;
    } rsp_t;

    typedef struct packed {
        logic      push_front;
        logic      push_rear;
        logic      pop_rd;
        logic      scan_start;
        logic      scan_step;
        logic      rsp_load;
        rsp_kind_t rsp_kind;
        status_t   rsp_status;
    } ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic hit;
        logic last;
    } sts_t;

endpackage

// ===== rtl/deque_with_search.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH words with push front, push rear, pop rear and
// linear search from the front. A command beat is taken when start is high
// and busy is low; its single result is shown on rsp for one cycle with done
// high and must be captured then, as there is no way to hold it. Pushes, and
// pops or searches on an empty store, answer in the cycle after the command;
// any other pop answers only after passing through S_POP, because the store
// is a RAM with registered read.
// A search reads one entry per cycle through that read port and answers
// once the first matching entry has been compared, or after the last entry
// when nothing matches. A new command may be given in the cycle its
// predecessor's result is shown.

module deque_with_search #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dws_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done,
    output dws_pkg::rsp_t rsp
);

    dws_pkg::ctl_t ctl;
    dws_pkg::sts_t sts;

    dws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (cmd.operation),
        .sts       (sts),
        .ctl       (ctl),
        .busy      (busy)
    );

    dws_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp),
        .done  (done)
    );

    // a push answers in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (cmd.operation == dws_pkg::OP_PUSH_FRONT ||
                           cmd.operation == dws_pkg::OP_PUSH_REAR) |=> done)
    else $error("push beat without result in next cycle");

    // no result while a pop or search is still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
    else $error("result shown while busy");

    // a position is reported only for a successful search
    assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != dws_pkg::ST_OK |-> rsp.found_position == '0)
    else $error("position reported with non-ok status");

    // a failed operation never returns a word
    assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status != dws_pkg::ST_OK |-> rsp.popped_value == '0)
    else $error("popped word reported with non-ok status");

endmodule

// ===== rtl/dws_ram.sv =====
`timescale 1ns / 1ps

module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/dws_ctrl.sv =====
`timescale 1ns / 1ps

module dws_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dws_pkg::op_t  operation,
    input  dws_pkg::sts_t sts,
    output dws_pkg::ctl_t ctl,
    output logic          busy
);

    dws_pkg::state_t state_reg;
    dws_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dws_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dws_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (operation == dws_pkg::OP_POP_REAR && !sts.empty)
                    begin
                        state_next = dws_pkg::S_POP;
                    end
                    else if (operation == dws_pkg::OP_SEARCH && !sts.empty)
                    begin
                        state_next = dws_pkg::S_SCAN;
                    end
                end
            end
            dws_pkg::S_POP:
            begin
                state_next = dws_pkg::S_IDLE;
            end
            dws_pkg::S_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    state_next = dws_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dws_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl            = '0;
        ctl.rsp_kind   = dws_pkg::RK_STATUS;
        ctl.rsp_status = dws_pkg::ST_OK;
        busy           = 1'b1;
        case (state_reg)
            dws_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (operation)
                        dws_pkg::OP_PUSH_FRONT,
                        dws_pkg::OP_PUSH_REAR:
                        begin
                            ctl.rsp_load = 1'b1;
                            if (sts.full)
                            begin
                                ctl.rsp_status = dws_pkg::ST_FULL;
                            end
                            else if (operation == dws_pkg::OP_PUSH_FRONT)
                            begin
                                ctl.push_front = 1'b1;
                            end
                            else
                            begin
                                ctl.push_rear = 1'b1;
                            end
                        end
                        dws_pkg::OP_POP_REAR:
                        begin
                            if (sts.empty)
                            begin
                                ctl.rsp_load   = 1'b1;
                                ctl.rsp_status = dws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.pop_rd = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (sts.empty)
                            begin
                                ctl.rsp_load   = 1'b1;
                                ctl.rsp_status = dws_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctl.scan_start = 1'b1;
                            end
                        end
                    endcase
                end
            end
            dws_pkg::S_POP:
            begin
                ctl.rsp_load = 1'b1;
                ctl.rsp_kind = dws_pkg::RK_POP;
            end
            dws_pkg::S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.hit)
                begin
                    ctl.rsp_load = 1'b1;
                    ctl.rsp_kind = dws_pkg::RK_HIT;
                end
                else if (sts.last)
                begin
                    ctl.rsp_load   = 1'b1;
                    ctl.rsp_status = dws_pkg::ST_MISS;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/dws_dp.sv =====
`timescale 1ns / 1ps

module dws_dp #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dws_pkg::cmd_t cmd,
    input  dws_pkg::ctl_t ctl,
    output dws_pkg::sts_t sts,
    output dws_pkg::rsp_t rsp,
    output logic          done
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0]         front_reg;
    logic [IW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         idx_next;
    logic                  cmp_valid_reg;
    logic                  cmp_valid_next;
    logic [CW-1:0]         cmp_pos_reg;
    logic [CW-1:0]         cmp_pos_next;
    logic [WORD_WIDTH-1:0] key_reg;
    logic [WORD_WIDTH-1:0] key_next;
    dws_pkg::rsp_t         rsp_reg;
    dws_pkg::rsp_t         rsp_next;
    logic                  done_reg;

    logic [WORD_WIDTH+dws_pkg::VALUE_W-1:0] word_wide;
    logic [WORD_WIDTH-1:0]                  word_in;
    logic [WORD_WIDTH+dws_pkg::VALUE_W-1:0] pop_wide;
    logic [CW+dws_pkg::POS_W-1:0]           pos_wide;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic                  ram_re;
    logic [IW-1:0]         ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;

    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign word_wide = {{WORD_WIDTH{1'b0}}, cmd.value};
    assign word_in   = word_wide[WORD_WIDTH-1:0];
    assign pop_wide  = {{dws_pkg::VALUE_W{ram_rdata[WORD_WIDTH-1]}}, ram_rdata};
    assign pos_wide  = {{dws_pkg::POS_W{1'b0}}, cmp_pos_reg};

    assign sts.full  = (count_reg == CW'(DEPTH));
    assign sts.empty = (count_reg == '0);
    assign sts.hit   = cmp_valid_reg && (ram_rdata == key_reg);
    assign sts.last  = cmp_valid_reg && (cmp_pos_reg == count_reg);

    always_comb
    begin
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_pos_next   = cmp_pos_reg;
        key_next       = key_reg;
        ram_we         = 1'b0;
        ram_waddr      = ring_add(front_reg, count_reg);
        ram_re         = 1'b0;
        ram_raddr      = ring_add(front_reg, idx_reg);

        if (ctl.push_front)
        begin
            front_next = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - IW'(1);
            ram_we     = 1'b1;
            ram_waddr  = front_next;
            count_next = count_reg + CW'(1);
        end
        else if (ctl.push_rear)
        begin
            ram_we     = 1'b1;
            count_next = count_reg + CW'(1);
        end

        if (ctl.pop_rd)
        begin
            ram_re     = 1'b1;
            ram_raddr  = ring_add(front_reg, count_reg - CW'(1));
            count_next = count_reg - CW'(1);
        end

        if (ctl.scan_start)
        begin
            idx_next       = '0;
            cmp_valid_next = 1'b0;
            key_next       = word_in;
        end
        else if (ctl.scan_step)
        begin
            if (idx_reg < count_reg)
            begin
                ram_re         = 1'b1;
                idx_next       = idx_reg + CW'(1);
                cmp_valid_next = 1'b1;
                cmp_pos_next   = idx_reg + CW'(1);
            end
            else
            begin
                cmp_valid_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        rsp_next                = rsp_reg;
        if (ctl.rsp_load)
        begin
            rsp_next.status         = ctl.rsp_status;
            rsp_next.popped_value   = '0;
            rsp_next.found_position = '0;
            case (ctl.rsp_kind)
                dws_pkg::RK_POP:
                begin
                    rsp_next.popped_value = pop_wide[dws_pkg::VALUE_W-1:0];
                end
                dws_pkg::RK_HIT:
                begin
                    rsp_next.found_position = pos_wide[dws_pkg::POS_W-1:0];
                end
                default:
                begin
                    rsp_next.popped_value = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= ctl.rsp_load;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_pos_reg <= cmp_pos_next;
        key_reg     <= key_next;
        rsp_reg     <= rsp_next;
    end

    dws_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

// ===== tb/dws_checker.sv =====
`timescale 1ns / 1ps

module dws_checker
    import dws_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  cmd_t  cmd,
    input  logic  done,
    input  rsp_t  rsp,
    output int    errors,
    output int    pending
);

    logic [VALUE_W-1:0] slots [DEPTH];
    int unsigned        head;
    int unsigned        fill;
    rsp_t               expected_rsps [$];
    rsp_t               want;

    task automatic report_mismatch(input string what);
        $display("check: %s at %0t", what, $time);
        errors++;
    endtask

    // apply one command to the shadow deque and return its result
    function automatic rsp_t deque_apply(input cmd_t c);
        rsp_t        r;
        int unsigned k;
        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_PUSH_FRONT:
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    slots[head] = c.value;
                    fill++;
                end
            OP_PUSH_REAR:
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slots[(head + fill) % DEPTH] = c.value;
                    fill++;
                end
            OP_POP_REAR:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.popped_value = slots[(head + fill - 1) % DEPTH];
                    fill--;
                end
            default:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status = ST_MISS;
                    for (k = 0; k < fill && r.status == ST_MISS; k++)
                    begin
                        if (slots[(head + k) % DEPTH] == c.value)
                        begin
                            r.status = ST_OK;
                            r.found_position = POS_W'(k + 1);
                        end
                    end
                end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            fill = 0;
            expected_rsps.delete();
            pending <= 0;
        end
        else
        begin
            // result beat first, so a command taken on the same edge queues behind it
            if (done)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("result beat with nothing outstanding");
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.popped_value !== want.popped_value)
                        report_mismatch($sformatf("popped_value got %h want %h",
                                                  rsp.popped_value, want.popped_value));
                    if (rsp.found_position !== want.found_position)
                        report_mismatch($sformatf("found_position got %0d want %0d",
                                                  rsp.found_position, want.found_position));
                end
            end
            if (start && !busy)
                expected_rsps.push_back(deque_apply(cmd));
            pending <= expected_rsps.size();
        end
    end

endmodule

// ===== tb/deque_with_search_tb.sv =====
`timescale 1ns / 1ps

module deque_with_search_tb;

    import dws_pkg::*;

    localparam int DEPTH            = 16;
    localparam int WORD_WIDTH       = 32;
    localparam int RANDOM_PER_PHASE = 450;
    localparam int STALL_LIMIT      = 500;
    localparam int DRAIN_CYCLES     = 40;
    localparam int POOL_SIZE        = 8;

    logic clk;
    logic rst_n;
    logic start;
    cmd_t cmd;
    logic busy;
    logic done;
    rsp_t rsp;

    int errors;
    int pending;
    int gap_pct;
    int stall_cycles;
    int run_left;
    bit filling;
    int i;

    logic [VALUE_W-1:0] word_pool [POOL_SIZE];

    deque_with_search #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    dws_checker #(
        .DEPTH (DEPTH)
    ) u_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // drive one command beat and return at the edge that takes it
    task automatic issue(input op_t op, input logic [VALUE_W-1:0] v);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct)
                @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{operation: op, value: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // alternate fill and drain runs so the store reaches full and empty often
    task automatic random_beat();
        int                 pick;
        op_t                op;
        logic [VALUE_W-1:0] v;
        if (run_left == 0)
        begin
            filling  = !filling;
            run_left = $urandom_range(15, 60);
        end
        run_left--;
        if ($urandom_range(0, 19) == 0)
            word_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
        if ($urandom_range(0, 3) == 0)
            v = $urandom;
        else
            v = word_pool[$urandom_range(0, POOL_SIZE - 1)];
        pick = $urandom_range(0, 99);
        if (pick < 25)
            op = OP_SEARCH;
        else if (pick < (filling ? 40 : 85))
            op = OP_POP_REAR;
        else
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        issue(op, v);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        run_left     = 0;
        filling      = 1'b0;
        gap_pct      = 18;
        word_pool[0] = 32'h8000_0000;
        word_pool[1] = 32'h7fff_ffff;
        word_pool[2] = 32'h0000_0000;
        word_pool[3] = 32'hffff_ffff;
        for (i = 4; i < POOL_SIZE; i++)
            word_pool[i] = $urandom;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        issue(OP_SEARCH, 32'h0000_0000);
        issue(OP_POP_REAR, 32'hffff_ffff);
        // extremes at both ends, duplicate key
        issue(OP_PUSH_REAR, 32'h7fff_ffff);
        issue(OP_PUSH_FRONT, 32'h8000_0000);
        issue(OP_PUSH_REAR, 32'h0000_0000);
        issue(OP_PUSH_FRONT, 32'hffff_ffff);
        issue(OP_PUSH_REAR, 32'h8000_0000);
        issue(OP_SEARCH, 32'h8000_0000);
        issue(OP_SEARCH, 32'h0000_0000);
        issue(OP_SEARCH, 32'h5a5a_5a5a);
        issue(OP_POP_REAR, 32'h0000_0000);
        // fill up, then pushes on a full store and a scan over all entries
        for (i = 1; i <= 12; i++)
            issue(OP_PUSH_REAR, i);
        issue(OP_PUSH_FRONT, 32'h1111_1111);
        issue(OP_PUSH_REAR, 32'h2222_2222);
        issue(OP_SEARCH, 32'd12);
        issue(OP_SEARCH, 32'h5a5a_5a5a);

        repeat (RANDOM_PER_PHASE)
            random_beat();
        gap_pct = 49;
        repeat (RANDOM_PER_PHASE)
            random_beat();
        gap_pct = 0;
        repeat (RANDOM_PER_PHASE)
            random_beat();

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
